FILE: rtl/core/grm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grm_pkg: shared types and constants for the grid rotate/mirror view
// Field widths, register indexes, transform codes and default parameters.
// ----------------------------------------------------------------------------
package grm_pkg;

    localparam int DEF_MAX_DIM   = 16;
    localparam int DEF_CELL_BITS = 32;

    localparam int IDX_W   = 4;   // row/column index field
    localparam int DIM_W   = 5;   // dimension registers and view dimensions
    localparam int DATA_W  = 32;  // cell_value and read_value fields
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [DIM_W-1:0] ROW_COUNT_RST = DIM_W'(2);
    localparam logic [DIM_W-1:0] COL_COUNT_RST = DIM_W'(2);

    typedef enum logic [2:0] {
        MODE_NONE  = 3'd0,
        MODE_ROT_R = 3'd1,
        MODE_ROT_2 = 3'd2,
        MODE_ROT_L = 3'd3,
        MODE_MIR_H = 3'd4,
        MODE_MIR_V = 3'd5,
        MODE_DIAG  = 3'd6,
        MODE_ADIAG = 3'd7
    } t_mode;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_ROW_COUNT = 2'd0,
        REG_COL_COUNT = 2'd1,
        REG_XFORM     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] row_count;
        logic [DIM_W-1:0] col_count;
        t_mode            mode;
    } t_cfg;

    // access decision for one item, from the address mapper
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic             err;
        logic [DIM_W-1:0] view_rows;
        logic [DIM_W-1:0] view_cols;
    } t_acc;

endpackage
`default_nettype wire

FILE: rtl/core/grm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grm_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface grm_req_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [grm_pkg::IDX_W-1:0]        row_index;
    logic [grm_pkg::IDX_W-1:0]        col_index;
    logic [grm_pkg::DATA_W-1:0]       cell_value;

    modport source (output valid, operation, row_index, col_index, cell_value,
                    input ready);
    modport sink   (input valid, operation, row_index, col_index, cell_value,
                    output ready);
endinterface

interface grm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [grm_pkg::DATA_W-1:0]       read_value;
    logic                             range_error;
    logic [grm_pkg::DIM_W-1:0]        view_rows;
    logic [grm_pkg::DIM_W-1:0]        view_cols;

    modport source (output valid, read_value, range_error, view_rows, view_cols,
                    input ready);
    modport sink   (input valid, read_value, range_error, view_rows, view_cols,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/core/grm_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grm_cfg: configuration registers
// APB-style register file holding grid dimensions and the transform mode.
// ----------------------------------------------------------------------------
module grm_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [grm_pkg::APB_AW-1:0]    paddr,
    input  wire logic [grm_pkg::APB_DW-1:0]    pwdata,
    output logic      [grm_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    output grm_pkg::t_cfg                      o_cfg
);

    logic [grm_pkg::DIM_W-1:0] r_row_count;
    logic [grm_pkg::DIM_W-1:0] r_col_count;
    grm_pkg::t_mode            r_mode;
    grm_pkg::t_reg_idx         reg_idx;
    logic                      wr_strobe;

    assign pready    = 1'b1;
    assign reg_idx   = grm_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_strobe = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= grm_pkg::ROW_COUNT_RST;
            r_col_count <= grm_pkg::COL_COUNT_RST;
            r_mode      <= grm_pkg::MODE_NONE;
        end else if (wr_strobe) begin
            unique case (reg_idx)
                grm_pkg::REG_ROW_COUNT: r_row_count <= pwdata[grm_pkg::DIM_W-1:0];
                grm_pkg::REG_COL_COUNT: r_col_count <= pwdata[grm_pkg::DIM_W-1:0];
                grm_pkg::REG_XFORM:     r_mode      <= grm_pkg::t_mode'(pwdata[2:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            grm_pkg::REG_ROW_COUNT: prdata = grm_pkg::APB_DW'(r_row_count);
            grm_pkg::REG_COL_COUNT: prdata = grm_pkg::APB_DW'(r_col_count);
            grm_pkg::REG_XFORM:     prdata = grm_pkg::APB_DW'(r_mode);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg.row_count = r_row_count;
    assign o_cfg.col_count = r_col_count;
    assign o_cfg.mode      = r_mode;

endmodule
`default_nettype wire

FILE: rtl/core/grm_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grm_map: view-to-source address mapper
// Clamps the dimensions, range-checks the coordinates and maps a view
// coordinate of a read through the selected transform to a store address;
// a write goes to its coordinate as given.
module grm_map #(
    parameter  int MAX_DIM = grm_pkg::DEF_MAX_DIM,
    localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM)
) (
    input  wire grm_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_fire,
    input  wire logic                          i_operation,
    input  wire logic [grm_pkg::IDX_W-1:0]     i_row_index,
    input  wire logic [grm_pkg::IDX_W-1:0]     i_col_index,
    output logic      [ADDR_W-1:0]             o_addr,
    output grm_pkg::t_acc                      o_acc
);

    localparam int DW = grm_pkg::DIM_W;

    logic [DW-1:0] nr, nc, sq, vr, vc, r, c, sr, sc;
    logic          swap, in_src, in_view, in_sq;

    function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
        logic [DW-1:0] res;
        if (v == '0)
            res = DW'(1);
        else if (32'(v) > MAX_DIM)
            res = DW'(MAX_DIM);
        else
            res = v;
        return res;
    endfunction

    always_comb begin
        nr   = eff_dim(i_cfg.row_count);
        nc   = eff_dim(i_cfg.col_count);
        sq   = (nr < nc) ? nr : nc;
        swap = (i_cfg.mode == grm_pkg::MODE_ROT_R) || (i_cfg.mode == grm_pkg::MODE_ROT_L);
        vr   = swap ? nc : nr;
        vc   = swap ? nr : nc;
        r    = DW'(i_row_index);
        c    = DW'(i_col_index);

        in_src  = (r < nr) && (c < nc);
        in_view = (r < vr) && (c < vc);
        in_sq   = (r < sq) && (c < sq);

        sr = r;
        sc = c;
        case (i_cfg.mode)
            grm_pkg::MODE_ROT_R: begin
                sr = nr - DW'(1) - c;
                sc = r;
            end
            grm_pkg::MODE_ROT_2: begin
                sr = nr - DW'(1) - r;
                sc = nc - DW'(1) - c;
            end
            grm_pkg::MODE_ROT_L: begin
                sr = c;
                sc = nc - DW'(1) - r;
            end
            grm_pkg::MODE_MIR_H: sc = nc - DW'(1) - c;
            grm_pkg::MODE_MIR_V: sr = nr - DW'(1) - r;
            grm_pkg::MODE_DIAG: begin
                if (in_sq) begin
                    sr = c;
                    sc = r;
                end
            end
            grm_pkg::MODE_ADIAG: begin
                if (in_sq) begin
                    sr = sq - DW'(1) - c;
                    sc = sq - DW'(1) - r;
                end
            end
            default: ;
        endcase

        // writes go to the source coordinate as given
        if (i_operation == grm_pkg::OP_WRITE)
            o_addr = ADDR_W'(32'(r) * MAX_DIM + 32'(c));
        else
            o_addr = ADDR_W'(32'(sr) * MAX_DIM + 32'(sc));

        o_acc.wr_en     = i_fire && (i_operation == grm_pkg::OP_WRITE) && in_src;
        o_acc.rd_en     = i_fire && (i_operation == grm_pkg::OP_READ) && in_view;
        o_acc.err       = (i_operation == grm_pkg::OP_WRITE) ? !in_src : !in_view;
        o_acc.view_rows = vr;
        o_acc.view_cols = vc;
    end

endmodule
`default_nettype wire

FILE: rtl/core/grm_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grm_store: cell storage
// Single-port synchronous memory, one write or one read per cycle,
// registered read data.
// ----------------------------------------------------------------------------
module grm_store #(
    parameter  int MAX_DIM   = grm_pkg::DEF_MAX_DIM,
    parameter  int CELL_BITS = grm_pkg::DEF_CELL_BITS,
    localparam int DEPTH     = MAX_DIM * MAX_DIM,
    localparam int ADDR_W    = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic                  i_rd_en,
    input  wire logic [ADDR_W-1:0]     i_addr,
    input  wire logic [CELL_BITS-1:0]  i_wr_data,
    output logic      [CELL_BITS-1:0]  o_rd_data
);

    logic [CELL_BITS-1:0] r_mem [DEPTH];
    logic [CELL_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en)
            r_mem[i_addr] <= i_wr_data;
    end

    // data holds until the next read, so a stalled result keeps its value
    always_ff @(posedge i_clk) begin
        if (i_rd_en)
            r_rd_data <= r_mem[i_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: rtl/core/grid_rotate_mirror_view.sv
// Grid rotate/mirror view. Holds up to MAX_DIM x MAX_DIM cells of CELL_BITS
// each in one single-port synchronous memory and answers reads through the
// transform chosen in the XFORM register. A request costs at most one memory
// access: the address is mapped and the memory written or read in the cycle of
// its transfer; the access stage then holds the request, and from it the
// output register is loaded, which presents the response. With the response
// side ready one request is accepted every cycle; a response held by the sink
// stops the request side once the access stage behind it is occupied too. The
// store is not cleared at reset: reading a cell that was never written returns
// an arbitrary value.
// Configuration registers may only be written while no request is in flight.
`default_nettype none
// ----------------------------------------------------------------------------
// grid_rotate_mirror_view: top level
// Config registers, address mapper, cell store and response pipeline.
// ----------------------------------------------------------------------------
module grid_rotate_mirror_view #(
    parameter  int MAX_DIM   = grm_pkg::DEF_MAX_DIM,
    parameter  int CELL_BITS = grm_pkg::DEF_CELL_BITS,
    localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [grm_pkg::APB_AW-1:0]    paddr,
    input  wire logic [grm_pkg::APB_DW-1:0]    pwdata,
    output logic      [grm_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    grm_req_if.sink                            i_req,
    grm_rsp_if.source                          o_rsp
);

    grm_pkg::t_cfg             cfg;
    grm_pkg::t_acc             acc;
    logic [ADDR_W-1:0]         addr;
    logic [CELL_BITS-1:0]      wr_data;
    logic [CELL_BITS-1:0]      rd_data;
    logic                      fire;
    logic                      s1_move;

    // access stage
    logic                      r_s1_valid;
    logic                      r_s1_rd;
    logic                      r_s1_err;
    logic [grm_pkg::DIM_W-1:0] r_s1_vr;
    logic [grm_pkg::DIM_W-1:0] r_s1_vc;

    // output register
    logic                      r_out_valid;
    logic [grm_pkg::DATA_W-1:0] r_out_value;
    logic                      r_out_err;
    logic [grm_pkg::DIM_W-1:0] r_out_vr;
    logic [grm_pkg::DIM_W-1:0] r_out_vc;

    grm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign s1_move     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_move;
    assign fire        = i_req.valid && i_req.ready;

    grm_map #(
        .MAX_DIM (MAX_DIM)
    ) u_map (
        .i_cfg       (cfg),
        .i_fire      (fire),
        .i_operation (i_req.operation),
        .i_row_index (i_req.row_index),
        .i_col_index (i_req.col_index),
        .o_addr      (addr),
        .o_acc       (acc)
    );

    assign wr_data = CELL_BITS'({{CELL_BITS{1'b0}}, i_req.cell_value});

    grm_store #(
        .MAX_DIM   (MAX_DIM),
        .CELL_BITS (CELL_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (acc.wr_en),
        .i_rd_en   (acc.rd_en),
        .i_addr    (addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_rd  <= acc.rd_en;
            r_s1_err <= acc.err;
            r_s1_vr  <= acc.view_rows;
            r_s1_vc  <= acc.view_cols;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // writes and out-of-range reads answer zero
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_value <= r_s1_rd ? grm_pkg::DATA_W'({{grm_pkg::DATA_W{1'b0}}, rd_data})
                                   : '0;
            r_out_err   <= r_s1_err;
            r_out_vr    <= r_s1_vr;
            r_out_vc    <= r_s1_vc;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_out_value;
    assign o_rsp.range_error = r_out_err;
    assign o_rsp.view_rows   = r_out_vr;
    assign o_rsp.view_cols   = r_out_vc;

endmodule
`default_nettype wire
